FILE: rtl/hsl_saturation_adjust_top_macros.svh
// Assertion helpers used by the checker file of this block.
`ifndef HSL_SATURATION_ADJUST_TOP_MACROS_SVH
`define HSL_SATURATION_ADJUST_TOP_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define HSL_SAT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hsl_sat: property violated");

// Same, with a caller supplied message.
`define HSL_SAT_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: rtl/hsl_sat_pkg.sv
package hsl_sat_pkg;

  // Cycles from an accepted item to its result strobe.
  localparam int unsigned LATENCY = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Payload through the saturation divider.
  typedef struct packed {
    rgb_t       pix;
    logic [7:0] lum;
    logic [8:0] den;
    logic [8:0] rem;
    logic [7:0] quo;
  } div_t;

  typedef struct packed {
    logic       q;
    logic [8:0] rem;
  } step_t;

  // Payload into the channel mixer.
  typedef struct packed {
    rgb_t        pix;
    logic [8:0]  diff_red;
    logic [8:0]  diff_green;
    logic [8:0]  diff_blue;
    logic [14:0] gain;
  } mix_t;

  // Clip the level to -100..100 and scale to trunc(level*128/100).
  function automatic logic signed [8:0] level_to_k(input logic signed [7:0] lvl);
    logic signed [7:0] clp;
    logic        [6:0] mag;
    logic       [11:0] x;
    logic       [24:0] p;
    logic        [7:0] q;
    clp = lvl;
    if (lvl < -8'sd100) begin
      clp = -8'sd100;
    end else if (lvl > 8'sd100) begin
      clp = 8'sd100;
    end
    mag = clp[7] ? 7'(-clp) : clp[6:0];
    x   = {mag, 5'b0};
    // x/25 by reciprocal; exact for x up to 3200
    p   = 25'(x) * 25'(13'd5243);
    q   = p[24:17];
    return clp[7] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // One restoring division step on a partial remainder below 2*den.
  function automatic step_t div_step(input logic [9:0] t, input logic [8:0] den);
    step_t s;
    if (t >= {1'b0, den}) begin
      s.q   = 1'b1;
      s.rem = 9'(t - {1'b0, den});
    end else begin
      s.q   = 1'b0;
      s.rem = t[8:0];
    end
    return s;
  endfunction

endpackage

FILE: rtl/hsl_sat_minmax.sv
module hsl_sat_minmax (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  hsl_sat_pkg::rgb_t pix_i,
  output logic              valid_o,
  output hsl_sat_pkg::div_t data_o
);

  logic              valid_q;
  hsl_sat_pkg::div_t data_d, data_q;

  always_comb begin
    logic [7:0] mn, mx;
    logic [8:0] sum;
    mn = pix_i.red;
    mx = pix_i.red;
    if (pix_i.green < mn) mn = pix_i.green;
    if (pix_i.green > mx) mx = pix_i.green;
    if (pix_i.blue < mn) mn = pix_i.blue;
    if (pix_i.blue > mx) mx = pix_i.blue;
    sum         = {1'b0, mx} + {1'b0, mn};
    data_d.pix  = pix_i;
    data_d.lum  = sum[8:1];
    // light half measures against the distance to white
    data_d.den  = sum[8] ? 9'(10'd510 - {1'b0, sum}) : sum;
    data_d.rem  = {1'b0, mx - mn};
    data_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/hsl_sat_divider.sv
module hsl_sat_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  hsl_sat_pkg::div_t data_i,
  output logic              valid_o,
  output hsl_sat_pkg::div_t data_o
);

  // Four stages, two quotient bits each, most significant first.
  logic              valid_q [4];
  hsl_sat_pkg::div_t data_q  [4];

  for (genvar st = 0; st < 4; st++) begin : g_stage
    logic              vin;
    hsl_sat_pkg::div_t cur, nxt;
    hsl_sat_pkg::step_t sa, sb;
    logic [9:0]        ta;

    if (st == 0) begin : g_first
      assign vin = valid_i;
      assign cur = data_i;
      // top bit: remainder is the delta itself, no doubling
      assign ta  = {1'b0, cur.rem};
    end else begin : g_next
      assign vin = valid_q[st-1];
      assign cur = data_q[st-1];
      assign ta  = {cur.rem, 1'b0};
    end

    always_comb begin
      sa       = hsl_sat_pkg::div_step(ta, cur.den);
      sb       = hsl_sat_pkg::div_step({sa.rem, 1'b0}, cur.den);
      nxt      = cur;
      nxt.rem  = sb.rem;
      nxt.quo  = {cur.quo[5:0], sa.q, sb.q};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[st] <= 1'b0;
      end else begin
        valid_q[st] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      data_q[st] <= nxt;
    end
  end

  assign valid_o = valid_q[3];
  assign data_o  = data_q[3];

endmodule

FILE: rtl/hsl_sat_gain.sv
module hsl_sat_gain (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic signed [8:0] k_i,
  input  logic              valid_i,
  input  hsl_sat_pkg::div_t data_i,
  output logic              valid_o,
  output hsl_sat_pkg::mix_t data_o
);

  // 16384/dv - 128 for dv in 1..128; dv of zero reads as one
  logic [13:0] recip [256];

  for (genvar i = 0; i < 256; i++) begin : g_recip
    localparam int DV = (i == 0) ? 1 : i;
    localparam int GV = (i <= 128) ? (16384 / DV - 128) : 0;
    assign recip[i] = 14'(GV);
  end

  logic              v1_q, v2_q;
  hsl_sat_pkg::rgb_t pix1_q;
  logic [8:0]        dr1_q, dg1_q, db1_q;
  logic [7:0]        dv_d, dv1_q;
  logic              neg1_q;
  hsl_sat_pkg::mix_t mix_d, mix_q;

  always_comb begin
    logic [8:0] ksum;
    ksum = {1'b0, k_i[7:0]} + {1'b0, data_i.quo};
    dv_d = (ksum >= 9'd128) ? data_i.quo : 8'(8'd128 - k_i[7:0]);
    if (dv_d == 8'd0) dv_d = 8'd1;
  end

  always_comb begin
    mix_d.pix        = pix1_q;
    mix_d.diff_red   = dr1_q;
    mix_d.diff_green = dg1_q;
    mix_d.diff_blue  = db1_q;
    mix_d.gain       = neg1_q ? {{6{k_i[8]}}, k_i} : {1'b0, recip[dv1_q]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix1_q <= data_i.pix;
    dr1_q  <= {1'b0, data_i.pix.red}   - {1'b0, data_i.lum};
    dg1_q  <= {1'b0, data_i.pix.green} - {1'b0, data_i.lum};
    db1_q  <= {1'b0, data_i.pix.blue}  - {1'b0, data_i.lum};
    dv1_q  <= dv_d;
    neg1_q <= k_i[8];
    mix_q  <= mix_d;
  end

  assign valid_o = v2_q;
  assign data_o  = mix_q;

endmodule

FILE: rtl/hsl_sat_mix.sv
module hsl_sat_mix (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  hsl_sat_pkg::mix_t data_i,
  output logic              valid_o,
  output hsl_sat_pkg::rgb_t pix_o
);

  logic                     vm_q, vf_q;
  hsl_sat_pkg::rgb_t        pixm_q, pix_d, pix_q;
  logic signed [23:0]       pr_q, pg_q, pb_q;

  function automatic logic [7:0] apply(input logic [7:0] c, input logic signed [23:0] p);
    logic signed [24:0] ext;
    logic signed [24:0] val;
    // floor division by 128: keep the sign through the shift
    ext = $signed({p[23], p}) >>> 7;
    val = $signed({17'b0, c}) + ext;
    if (val < 25'sd0) return 8'd0;
    if (val > 25'sd255) return 8'd255;
    return val[7:0];
  endfunction

  always_comb begin
    pix_d.red   = apply(pixm_q.red,   pr_q);
    pix_d.green = apply(pixm_q.green, pg_q);
    pix_d.blue  = apply(pixm_q.blue,  pb_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      vm_q <= valid_i;
      vf_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pixm_q <= data_i.pix;
    pr_q   <= $signed(data_i.diff_red)   * $signed(data_i.gain);
    pg_q   <= $signed(data_i.diff_green) * $signed(data_i.gain);
    pb_q   <= $signed(data_i.diff_blue)  * $signed(data_i.gain);
    pix_q  <= pix_d;
  end

  assign valid_o = vf_q;
  assign pix_o   = pix_q;

endmodule

FILE: rtl/hsl_saturation_adjust_top.sv
// Channel    | Direction | Handshake                    | Payload
// pixel in   | in        | start high, busy low         | red_in_i, green_in_i, blue_in_i
// pixel out  | out       | result_valid_o, one cycle    | red_out_o, green_out_o, blue_out_o
// config     | in        | cfg_we_i                     | cfg_wdata_i (saturation level)
//
// One item per clock; busy stays low, so start is taken on every cycle.
// Each result passes through ten register stages: input, min/max, four
// divider stages of two quotient bits, gain select, gain lookup, channel
// multiply, clip and output.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets the level
// to zero. The receiver cannot stall, so nothing ever holds in the pipe.
module hsl_saturation_adjust_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  output logic       result_valid_o,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  // Strength k, clipped and scaled once at write time.
  logic signed [8:0] k_q;

  logic              in_valid_q;
  hsl_sat_pkg::rgb_t in_pix_q;

  logic              mm_valid, dv_valid, gn_valid, mx_valid;
  hsl_sat_pkg::div_t mm_data, dv_data;
  hsl_sat_pkg::mix_t gn_data;
  hsl_sat_pkg::rgb_t mx_pix;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      in_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        k_q <= hsl_sat_pkg::level_to_k($signed(cfg_wdata_i));
      end
      in_valid_q <= start && !busy;
    end
  end

  // Capture the pixel; payload carries no reset.
  always_ff @(posedge clk_i) begin
    in_pix_q.red   <= red_in_i;
    in_pix_q.green <= green_in_i;
    in_pix_q.blue  <= blue_in_i;
  end

  // Find min, max, lightness and the saturation denominator.
  hsl_sat_minmax u_minmax (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .pix_i   (in_pix_q),
    .valid_o (mm_valid),
    .data_o  (mm_data)
  );

  // Saturation S = delta*128/den, two bits per stage.
  hsl_sat_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mm_valid),
    .data_i  (mm_data),
    .valid_o (dv_valid),
    .data_o  (dv_data)
  );

  // Pick the divisor from k and S and look up the gain; a negative k is the gain.
  hsl_sat_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .k_i     (k_q),
    .valid_i (dv_valid),
    .data_i  (dv_data),
    .valid_o (gn_valid),
    .data_o  (gn_data)
  );

  // Scale each channel's distance from lightness, clip and register out.
  hsl_sat_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (gn_valid),
    .data_i  (gn_data),
    .valid_o (mx_valid),
    .pix_o   (mx_pix)
  );

  assign result_valid_o = mx_valid;
  assign red_out_o      = mx_pix.red;
  assign green_out_o    = mx_pix.green;
  assign blue_out_o     = mx_pix.blue;

endmodule

FILE: rtl/hsl_sat_checker.sv
`include "hsl_saturation_adjust_top_macros.svh"

module hsl_sat_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [7:0] red_in_i,
  input logic [7:0] green_in_i,
  input logic [7:0] blue_in_i,
  input logic       result_valid_o,
  input logic [7:0] red_out_o,
  input logic [7:0] green_out_o,
  input logic [7:0] blue_out_o
);

  logic accepted;
  logic grey_in;

  assign accepted = start && !busy;
  assign grey_in  = (red_in_i == green_in_i) && (green_in_i == blue_in_i);

  `HSL_SAT_ASSERT(a_never_busy, clk_i, rst_ni, !busy)
  `HSL_SAT_ASSERT(a_result_follows, clk_i, rst_ni,
    accepted |-> ##10 result_valid_o)
  `HSL_SAT_ASSERT(a_no_spurious, clk_i, rst_ni,
    !accepted |-> ##10 !result_valid_o)
  `HSL_SAT_ASSERT_MSG(a_grey_passes, clk_i, rst_ni,
    (accepted && grey_in) |-> ##10 (red_out_o == $past(red_in_i, 10)
      && green_out_o == $past(green_in_i, 10) && blue_out_o == $past(blue_in_i, 10)),
    "hsl_sat: grey pixel changed")

endmodule

bind hsl_saturation_adjust_top hsl_sat_checker u_checker (.*);

FILE: tb/sv/hsl_saturation_adjust_top_tb.sv
module hsl_saturation_adjust_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 2;
  // Generous ceiling for 1524 items, with the sender idling up to 79 % of the time.
  localparam int CYCLE_LIMIT = 200_000;
  localparam int REPORT_MAX  = 10;
  localparam int RANDOM_PER_PHASE = 125;
  localparam int NUM_PHASES  = 12;
  localparam int NUM_DIRECTED = 12;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start  = 1'b0;
  logic       busy;
  logic [7:0] red_in_i   = '0;
  logic [7:0] green_in_i = '0;
  logic [7:0] blue_in_i  = '0;
  logic       result_valid_o;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = '0;

  // Pixels waiting to be offered, and adjusted pixels waiting to come back.
  hsl_sat_pkg::rgb_t pending_pixels[$];
  hsl_sat_pkg::rgb_t expected_pixels[$];

  // Level as last written into the block; only changes while it is idle.
  logic signed [7:0] level_now = '0;
  int sender_idle_pct = 0;
  logic item_taken = 1'b0;
  int cycle_count = 0;
  int pixels_checked = 0;
  int pixels_sent = 0;
  int failures = 0;
  int reports = 0;

  hsl_saturation_adjust_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .result_valid_o (result_valid_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Expected pixel after saturation adjustment at the given register level.
  function automatic hsl_sat_pkg::rgb_t adjust_saturation(hsl_sat_pkg::rgb_t px,
                                                          logic signed [7:0] lvl_reg);
    int   ch[3];
    int   lvl, k, mn, mx, delta, sum, lum, den, sat, dv, gain, v, i;
    hsl_sat_pkg::rgb_t res;
    ch[0] = px.red;
    ch[1] = px.green;
    ch[2] = px.blue;
    lvl = lvl_reg;
    if (lvl < -100) lvl = -100;
    if (lvl > 100) lvl = 100;
    // SV division truncates towards zero, matching the intended strength
    k = (lvl * 128) / 100;
    mn = ch[0];
    mx = ch[0];
    for (i = 1; i < 3; i++) begin
      if (ch[i] < mn) mn = ch[i];
      if (ch[i] > mx) mx = ch[i];
    end
    delta = mx - mn;
    sum   = mx + mn;
    if (lvl != 0 && delta != 0) begin
      lum = sum >>> 1;
      den = (lum < 128) ? sum : 510 - sum;
      if (den <= 0) den = 1;
      sat = (delta * 128) / den;
      if (k >= 0) begin
        dv = (k + sat >= 128) ? sat : 128 - k;
        if (dv <= 0) dv = 1;
        gain = 16384 / dv - 128;
      end else begin
        gain = k;
      end
      for (i = 0; i < 3; i++) begin
        // floor division by 128 through an arithmetic shift
        v = ch[i] + (((ch[i] - lum) * gain) >>> 7);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        ch[i] = v;
      end
    end
    res.red   = 8'(ch[0]);
    res.green = 8'(ch[1]);
    res.blue  = 8'(ch[2]);
    return res;
  endfunction

  // Corner pixels: extremes, primaries, greys, near-greys and the case where
  // saturation rounds to zero, giving a zero divisor at full strength.
  function automatic hsl_sat_pkg::rgb_t directed_pixel(int idx);
    hsl_sat_pkg::rgb_t p;
    case (idx)
      0:  p = '{8'd0,   8'd0,   8'd0};
      1:  p = '{8'd255, 8'd255, 8'd255};
      2:  p = '{8'd255, 8'd0,   8'd0};
      3:  p = '{8'd0,   8'd255, 8'd0};
      4:  p = '{8'd0,   8'd0,   8'd255};
      5:  p = '{8'd255, 8'd255, 8'd0};
      6:  p = '{8'd100, 8'd101, 8'd100};
      7:  p = '{8'd1,   8'd0,   8'd0};
      8:  p = '{8'd254, 8'd255, 8'd255};
      9:  p = '{8'd128, 8'd127, 8'd128};
      10: p = '{8'd12,  8'd200, 8'd77};
      default: p = '{8'd77, 8'd77, 8'd77};
    endcase
    return p;
  endfunction

  // Mostly uniform pixels, with a share of greys, near-greys and rail values.
  function automatic hsl_sat_pkg::rgb_t random_pixel();
    hsl_sat_pkg::rgb_t p;
    int   base;
    base = $urandom_range(255);
    p = hsl_sat_pkg::rgb_t'($urandom);
    case ($urandom_range(9))
      6: begin
        p.red   = 8'(base);
        p.green = 8'((base + $urandom_range(3)) > 255 ? 255 : base + $urandom_range(3));
        p.blue  = 8'((base < 3) ? base : base - $urandom_range(3));
      end
      7: begin
        p = '{8'(base), 8'(base), 8'(base)};
      end
      8: begin
        p.red   = $urandom_range(1) ? 8'd255 : 8'd0;
        p.blue  = $urandom_range(1) ? 8'd255 : 8'(base);
      end
      9: begin
        p = '{8'(base), 8'(base), 8'(base)};
        p.green = (base == 255) ? 8'd254 : 8'(base + 1);
      end
      default: ;
    endcase
    return p;
  endfunction

  // Driver: change inputs on the falling edge; hold an item until it is taken.
  always @(negedge clk_i) begin
    hsl_sat_pkg::rgb_t nxt;
    logic launch;
    launch = 1'b0;
    if (start && !item_taken) begin
      launch = 1'b1;
    end else if (rst_ni && pending_pixels.size() != 0
                 && $urandom_range(99) >= sender_idle_pct) begin
      nxt = pending_pixels.pop_front();
      red_in_i   <= nxt.red;
      green_in_i <= nxt.green;
      blue_in_i  <= nxt.blue;
      launch = 1'b1;
    end
    start <= launch;
  end

  // Monitor and predictor on the rising edge: check the oldest expectation
  // first, then log the item taken at this edge against the current level.
  always @(posedge clk_i) begin
    hsl_sat_pkg::rgb_t got, want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected",
               cycle_count, expected_pixels.size());
      $display("Some tests failed");
      $finish;
    end else begin
      if (rst_ni && result_valid_o) begin
        got = '{red_out_o, green_out_o, blue_out_o};
        if (expected_pixels.size() == 0) begin
          failures++;
          if (reports < REPORT_MAX) begin
            reports++;
            $display("cycle %0d: unexpected pixel %02h %02h %02h",
                     cycle_count, got.red, got.green, got.blue);
          end
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (got.red !== want.red || got.green !== want.green
              || got.blue !== want.blue) begin
            failures++;
            if (reports < REPORT_MAX) begin
              reports++;
              $display("cycle %0d: level %0d, expected %02h %02h %02h, got %02h %02h %02h",
                       cycle_count, level_now, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
            end
          end
        end
      end
      item_taken = rst_ni && start && !busy;
      if (item_taken) begin
        expected_pixels.push_back(
          adjust_saturation('{red_in_i, green_in_i, blue_in_i}, level_now));
        pixels_sent++;
      end
    end
  end

  // Hold until the sender has nothing left and every result has come back.
  task automatic wait_quiet();
    while (pending_pixels.size() != 0 || expected_pixels.size() != 0 || start)
      @(posedge clk_i);
  endtask

  // Write the level register on a falling edge for one cycle.
  task automatic write_level(input logic signed [7:0] lvl);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lvl;
    level_now    = lvl;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int phase_levels[NUM_PHASES];
    int idle_plan[4];
    int p, i, settle;
    phase_levels = '{100, -128, 127, -100, 0, -101, 101, 1, -1, 50, -37, 64};
    // Idle percentages cycled across phases, with flat-out phases in between.
    idle_plan = '{0, 79, 0, 14};
    // Last phase picks an arbitrary level, whatever the seed gives.
    phase_levels[NUM_PHASES-1] = int'($signed(8'($urandom_range(255))));

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_quiet();
      write_level(8'(phase_levels[p]));
      sender_idle_pct = idle_plan[p % 4];
      // Directed corners at full strength and at the strongest desaturation.
      if (p < 2) begin
        for (i = 0; i < NUM_DIRECTED; i++) pending_pixels.push_back(directed_pixel(i));
      end
      for (i = 0; i < RANDOM_PER_PHASE; i++) begin
        pending_pixels.push_back(random_pixel());
        // Once, drain the pipe completely in the middle of a phase.
        if (p == 3 && i == RANDOM_PER_PHASE / 2) wait_quiet();
      end
    end

    // Drop into the final drain: nothing left to send, bounded wait for results.
    while (pending_pixels.size() != 0 || start) @(posedge clk_i);
    settle = 0;
    while (expected_pixels.size() != 0 && settle < hsl_sat_pkg::LATENCY + 20) begin
      @(posedge clk_i);
      settle++;
    end
    repeat (hsl_sat_pkg::LATENCY + 2) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      failures += expected_pixels.size();
      $display("%0d expected pixels never arrived", expected_pixels.size());
    end

    $display("Sent %0d pixels (%0d directed), checked %0d, over %0d level settings",
             pixels_sent, 2 * NUM_DIRECTED, pixels_checked, NUM_PHASES);
    $display("Levels spanned -128..127 incl. zero and out-of-range; sender idle 0/14/79 %%");
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d failures", failures);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/hsl_sat_pkg.sv
rtl/hsl_sat_minmax.sv
rtl/hsl_sat_divider.sv
rtl/hsl_sat_gain.sv
rtl/hsl_sat_mix.sv
rtl/hsl_saturation_adjust_top.sv
rtl/hsl_sat_checker.sv
tb/sv/hsl_saturation_adjust_top_tb.sv
